FILE: sv/dqts_pkg.sv
package dqts_pkg;

    // Width of the running text offset; the offset saturates at its maximum.
    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 16;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Progress codes: octet n (0..3) uses 4n..4n+2; for n < 3, 4n+3 waits for a dot.
    localparam logic [3:0] PROG_IDLE     = 4'd0;
    localparam logic [3:0] PROG_OCT2     = 4'd4;
    localparam logic [3:0] PROG_OCT3     = 4'd8;
    localparam logic [3:0] PROG_OCT4     = 4'd12;
    localparam logic [3:0] PROG_OCT4_DIG = 4'd13;
    localparam logic [3:0] PROG_FULL     = 4'd15;

    localparam logic [1:0] MAX_SPACES = 2'd2;

    typedef struct packed {
        logic                hit;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] stop;
    } t_match;

endpackage

FILE: sv/dqts_in_if.sv
interface dqts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

FILE: sv/dqts_out_if.sv
interface dqts_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_start;
    logic [15:0] match_end;

    modport source (output valid, output match_start, output match_end, input ready);
    modport sink (input valid, input match_start, input match_end, output ready);
endinterface

FILE: sv/dqts_core.sv
module dqts_core
    import dqts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    output t_match     o_match
);

    typedef enum logic [1:0] {
        SCAN_TAKEN  = 2'd0,
        SCAN_BROKEN = 2'd1,
        SCAN_MATCH  = 2'd2
    } t_scan_res;

    typedef struct packed {
        logic [3:0]             progress;
        logic [1:0]             space_count;
        logic                   open;
        logic [OFFSET_BITS-1:0] start;
    } t_scan_st;

    typedef struct packed {
        t_scan_st  st;
        t_scan_res res;
    } t_scan_ret;

    t_scan_st               r_st;
    t_scan_st               n_st;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [OFFSET_BITS-1:0] n_offset;
    t_scan_ret              first;
    t_scan_ret              second;

    function automatic logic [OUT_BITS-1:0] f_low(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_BITS-1:0];
    endfunction

    function automatic t_scan_ret f_scan(input t_scan_st s, input logic [7:0] c,
                                         input logic [OFFSET_BITS-1:0] off);
        t_scan_ret  r;
        logic       digit;
        logic       taken;
        logic [3:0] k;
        r     = '{st: s, res: SCAN_TAKEN};
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        taken = 1'b0;
        k     = s.progress;
        if (k[1:0] != 2'b11) begin
            if (digit || (c == CH_SPACE && k < PROG_OCT4_DIG)) begin
                taken = 1'b1;
                if (k == PROG_IDLE) begin
                    r.st.start       = off;
                    r.st.open        = 1'b1;
                    r.st.space_count = 2'd0;
                end
                if (digit) begin
                    r.st.progress = k + 4'd1;
                end else if (r.st.space_count == MAX_SPACES) begin
                    // The third space in one octet drops the candidate.
                    r.st.progress    = PROG_IDLE;
                    r.st.open        = 1'b0;
                    r.st.space_count = 2'd0;
                end else begin
                    r.st.space_count = r.st.space_count + 2'd1;
                end
            end else if (c == CH_DOT && k <= PROG_OCT4 && k != PROG_IDLE) begin
                taken            = 1'b1;
                r.st.space_count = 2'd0;
                if (k > PROG_OCT3) begin
                    r.st.progress = PROG_OCT4;
                end else if (k > PROG_OCT2) begin
                    r.st.progress = PROG_OCT3;
                end else begin
                    r.st.progress = PROG_OCT2;
                end
            end
        end else if (c == CH_DOT && k != PROG_FULL) begin
            taken            = 1'b1;
            r.st.space_count = 2'd0;
            r.st.progress    = k + 4'd1;
        end
        if (!taken) begin
            r.st.progress = PROG_IDLE;
            if (s.open) begin
                r.st.open        = 1'b0;
                r.st.space_count = 2'd0;
                r.res            = (k > PROG_OCT4) ? SCAN_MATCH : SCAN_BROKEN;
            end
        end
        return r;
    endfunction

    // The byte that ends or breaks a candidate is scanned again from idle.
    assign first  = f_scan(r_st, i_ch, r_offset);
    assign second = f_scan(first.st, i_ch, r_offset);

    always_comb begin
        n_st          = r_st;
        n_offset      = r_offset;
        o_match.hit   = 1'b0;
        o_match.start = f_low(r_st.start);
        o_match.stop  = f_low(r_offset);
        if (i_ch == CH_END) begin
            o_match.hit = r_st.open && (r_st.progress > PROG_OCT4);
            n_st        = '0;
            n_offset    = '0;
        end else begin
            o_match.hit   = (first.res == SCAN_MATCH);
            o_match.start = f_low(first.st.start);
            n_st          = (first.res == SCAN_TAKEN) ? first.st : second.st;
            if (r_offset != {OFFSET_BITS{1'b1}}) begin
                n_offset = r_offset + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_offset <= '0;
        end else if (i_step) begin
            r_st     <= n_st;
            r_offset <= n_offset;
        end
    end

endmodule

FILE: sv/dotted_quad_text_scanner.sv
// An accepted byte is held in the input register, and its result is registered
// in the result register before it reaches the output.
// Throughput: one byte per cycle while the output side takes results; the only
// per-byte loop is the scan state update between the input and result registers.
// Reset (synchronous, active low) clears the scan state, the text offset and both
// valid flags; the block accepts bytes in the first cycle after reset.
module dotted_quad_text_scanner
    import dqts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqts_in_if.sink    i_in,
    dqts_out_if.source o_out
);

    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_out_valid;
    logic [15:0] r_start;
    logic [15:0] r_stop;
    logic        advance;
    logic        in_take;
    t_match      match;

    // The result register moves whenever it is empty or being drained.
    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    dqts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && advance),
        .i_ch    (r_ch),
        .o_match (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && match.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch <= i_in.ch;
        end
        if (advance) begin
            r_start <= match.start;
            r_stop  <= match.stop;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.match_start = r_start;
    assign o_out.match_end   = r_stop;

endmodule
